// ===== src/rbq_pkg.sv =====
// Shared definitions for the ring-of-buffers byte queue.
// Holds the default sizes, the fixed field widths and the action codes.
// No dependencies.
`timescale 1ns / 1ps

package rbq_pkg;

  // Default ring geometry
  localparam int unsigned DefBufferCount = 8;
  localparam int unsigned DefBufferBytes = 512;

  // Fixed widths of the item fields
  localparam int unsigned ActionW     = 2;
  localparam int unsigned WrOffsetW   = 9;
  localparam int unsigned WrDataW     = 8;
  localparam int unsigned CommitSizeW = 10;
  localparam int unsigned RdDataW     = 8;
  localparam int unsigned BytesAvailW = 13;

  // Largest commit size the field can carry
  localparam int unsigned CommitSizeMax = (1 << CommitSizeW) - 1;

  // Action codes carried in the input tuser
  typedef enum logic [ActionW-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

endpackage

// ===== src/ring_of_buffers_byte_queue_unit.sv =====
// Ring-of-buffers byte queue: top level with the access sequencer.
// Depends on rbq_pkg, rbq_byte_ram and rbq_fill_table.
//
// Usage:
//   Input items arrive on the s_axis channel. tuser carries the action
//   (write byte, commit buffer, read byte, none); tdata carries the write
//   offset, the write byte and the commit size. Every item yields exactly one
//   result item on the m_axis channel: the byte read, its valid flag, the
//   commit acknowledge and the count of committed bytes still unread.
//   Write, commit and idle actions load the result register on acceptance,
//   as does a read with nothing available. A read that returns a byte
//   fetches the fill lengths of the current and next buffer from the fill
//   table, then the byte from the byte RAM, then presents it in the result
//   register. A read that steps onto an empty committed buffer stops after
//   the fill fetch. Writes and commits are taken at 1 item per cycle while
//   the result register is not stalled; a read holds off further input until
//   its two dependent memory reads are through.
//   s_axis_tready is high while no read is in progress and the result
//   register is empty or being emptied in that cycle; a stalled receiver
//   holds the result and blocks further input.
//   After reset the ring is empty, the write buffer is buffer 1, the read
//   buffer is buffer 0 and every fill length reads as zero. Byte contents are
//   undefined until written; no clearing pass is run.
`timescale 1ns / 1ps

module ring_of_buffers_byte_queue_unit
  import rbq_pkg::*;
#(
  parameter int unsigned BUFFER_COUNT = DefBufferCount,
  parameter int unsigned BUFFER_BYTES = DefBufferBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] write_offset, [16:9] write_data, [26:17] commit_size, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] read_valid, [9] commit_accepted,
  // [22:10] bytes_available, [23] zero
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned IdxW       = $clog2(BUFFER_COUNT);
  localparam int unsigned StoreBytes = BUFFER_COUNT * BUFFER_BYTES;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned FillMax    =
    (BUFFER_BYTES < CommitSizeMax) ? BUFFER_BYTES : CommitSizeMax;
  localparam int unsigned FillW      = $clog2(FillMax + 1);
  localparam int unsigned AvailMax   = (BUFFER_COUNT - 1) * FillMax;
  localparam int unsigned AvailW     = $clog2(AvailMax + 1);
  localparam int unsigned LastIdx    = BUFFER_COUNT - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_BYTE
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     w_idx_q, w_idx_d;
  logic [IdxW-1:0]     r_idx_q, r_idx_d;
  logic [FillW-1:0]    pos_q, pos_d;
  logic [AvailW-1:0]   avail_q, avail_d;

  logic                out_valid_q;
  logic [RdDataW-1:0]  out_rdata_q, out_rdata_d;
  logic                out_rvalid_q, out_rvalid_d;
  logic                out_acc_q, out_acc_d;
  logic [AvailW-1:0]   out_avail_q;
  logic                out_load;

  action_e             act;
  logic [WrOffsetW-1:0]   wr_off;
  logic [WrDataW-1:0]     wr_data;
  logic [CommitSizeW-1:0] cmt_size;
  logic [FillW-1:0]    size_c;
  logic                in_acc;
  logic                out_free;

  logic                byte_we, byte_re;
  logic [AddrW-1:0]    byte_waddr, byte_raddr;
  logic [WrDataW-1:0]  byte_rdata;
  logic                fill_we, fill_re;
  logic [FillW-1:0]    fill_cur, fill_nxt;
  logic [IdxW-1:0]     r_nxt;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
    next_slot = (32'(idx) == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  // Unpack the input item
  assign act      = action_e'(s_axis_tuser[1:0]);
  assign wr_off   = s_axis_tdata[8:0];
  assign wr_data  = s_axis_tdata[16:9];
  assign cmt_size = s_axis_tdata[26:17];
  assign size_c   = (32'(cmt_size) > BUFFER_BYTES) ? FillW'(BUFFER_BYTES)
                                                   : FillW'(cmt_size);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign r_nxt         = next_slot(r_idx_q);

  // Sequence one item through the memories
  always_comb begin
    state_d      = state_q;
    w_idx_d      = w_idx_q;
    r_idx_d      = r_idx_q;
    pos_d        = pos_q;
    avail_d      = avail_q;
    out_load     = 1'b0;
    out_rdata_d  = '0;
    out_rvalid_d = 1'b0;
    out_acc_d    = 1'b0;
    byte_we      = 1'b0;
    byte_waddr   = AddrW'(32'(w_idx_q) * BUFFER_BYTES + 32'(wr_off));
    byte_re      = 1'b0;
    byte_raddr   = AddrW'(32'(r_idx_q) * BUFFER_BYTES + 32'(pos_q));
    fill_we      = 1'b0;
    fill_re      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_WRITE: begin
              byte_we  = (32'(wr_off) < BUFFER_BYTES);
              out_load = 1'b1;
            end
            ACT_COMMIT: begin
              if (next_slot(w_idx_q) != r_idx_q) begin
                fill_we   = 1'b1;
                w_idx_d   = next_slot(w_idx_q);
                avail_d   = avail_q + AvailW'(size_c);
                out_acc_d = 1'b1;
              end
              out_load = 1'b1;
            end
            ACT_READ: begin
              if (avail_q != '0) begin
                fill_re = 1'b1;
                state_d = ST_FILL;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        if (fill_cur > pos_q) begin
          // Take the next byte of the current buffer
          byte_re = 1'b1;
          pos_d   = pos_q + 1'b1;
          avail_d = avail_q - 1'b1;
          state_d = ST_BYTE;
        end else if (r_nxt != w_idx_q) begin
          // Move to the next committed buffer
          r_idx_d = r_nxt;
          pos_d   = '0;
          if (fill_nxt != '0) begin
            byte_re    = 1'b1;
            byte_raddr = AddrW'(32'(r_nxt) * BUFFER_BYTES);
            pos_d      = FillW'(1);
            avail_d    = avail_q - 1'b1;
            state_d    = ST_BYTE;
          end else begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_BYTE: begin
        out_load     = 1'b1;
        out_rdata_d  = byte_rdata;
        out_rvalid_d = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      w_idx_q      <= IdxW'(1);
      r_idx_q      <= '0;
      pos_q        <= '0;
      avail_q      <= '0;
      out_valid_q  <= 1'b0;
      out_rdata_q  <= '0;
      out_rvalid_q <= 1'b0;
      out_acc_q    <= 1'b0;
      out_avail_q  <= '0;
    end else begin
      state_q <= state_d;
      w_idx_q <= w_idx_d;
      r_idx_q <= r_idx_d;
      pos_q   <= pos_d;
      avail_q <= avail_d;
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_rdata_q  <= out_rdata_d;
        out_rvalid_q <= out_rvalid_d;
        out_acc_q    <= out_acc_d;
        out_avail_q  <= avail_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, BytesAvailW'(out_avail_q), out_acc_q, out_rvalid_q,
                          out_rdata_q};

  rbq_byte_ram #(
    .DEPTH  (StoreBytes),
    .ADDR_W (AddrW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (wr_data),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  rbq_fill_table #(
    .ENTRIES (BUFFER_COUNT),
    .IDX_W   (IdxW),
    .FILL_W  (FillW)
  ) u_fill_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (fill_we),
    .waddr_i   (w_idx_q),
    .wdata_i   (size_c),
    .re_i      (fill_re),
    .raddr_a_i (r_idx_q),
    .raddr_b_i (r_nxt),
    .rdata_a_o (fill_cur),
    .rdata_b_o (fill_nxt)
  );

  // The write buffer never catches up with the read buffer
  a_idx_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_idx_q != r_idx_q)
    else $error("write index reached read index");

  // Unread bytes never exceed what the committed buffers can hold
  a_avail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(avail_q) <= AvailMax)
    else $error("available count out of range");

  // The read position stays within one buffer
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= FillMax)
    else $error("read position out of range");

  // A byte fetch consumes exactly one available byte
  a_take_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_re |=> (avail_q == $past(avail_q) - 1'b1) && (state_q == ST_BYTE))
    else $error("byte fetch did not consume one byte");

endmodule

// ===== src/rbq_byte_ram.sv =====
// Byte storage of all ring buffers: one write port, one registered read port.
// Uses rbq_pkg for the byte width; no other dependencies.
`timescale 1ns / 1ps

module rbq_byte_ram
  import rbq_pkg::*;
#(
  parameter int unsigned DEPTH  = DefBufferCount * DefBufferBytes,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [WrDataW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [WrDataW-1:0] rdata_o
);

  logic [WrDataW-1:0] mem [DEPTH];
  logic [WrDataW-1:0] rdata_q;

  // Store the byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Fetch into a registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rbq_fill_table.sv =====
// Fill lengths of the ring buffers: one write port, two registered read ports.
// Per-entry valid bits make an entry read as zero until it is first written.
// No dependencies.
`timescale 1ns / 1ps

module rbq_fill_table #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned IDX_W   = $clog2(ENTRIES),
  parameter int unsigned FILL_W  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [FILL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_a_i,
  input  logic [IDX_W-1:0]  raddr_b_i,
  output logic [FILL_W-1:0] rdata_a_o,
  output logic [FILL_W-1:0] rdata_b_o
);

  logic [FILL_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [FILL_W-1:0]  data_a_q, data_b_q;
  logic               vld_a_q, vld_b_q;

  // Store the length
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Mark entries once written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Fetch both ports into registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (re_i) begin
      vld_a_q <= valid_q[raddr_a_i];
      vld_b_q <= valid_q[raddr_b_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      data_a_q <= mem[raddr_a_i];
      data_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = vld_a_q ? data_a_q : '0;
  assign rdata_b_o = vld_b_q ? data_b_q : '0;

endmodule
